FILE: hw/rtl/srq_pkg.sv
// Shared definitions for the strict-priority ready queue.
// Action codes, fixed field widths and default sizes.
// No dependencies.
package srq_pkg;

  // fixed field widths of the request and response words
  localparam int ACT_W  = 2;
  localparam int ID_W   = 4;
  localparam int PRIO_W = 2;

  // default sizing
  localparam int TASKS_DEF  = 16;
  localparam int LEVELS_DEF = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_SPAWN    = 2'd0,
    ACT_WAKE     = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_NOP      = 2'd3
  } action_t;

  // controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

FILE: hw/rtl/strict_priority_ready_queue.sv
// Strict-priority ready queue: per-level FIFOs of task ids kept as linked lists.
// A word is captured at accept and executed in S_EXEC, where its result word is registered.
// A new word is not accepted until the last one has left S_EXEC, since the link and
// level RAMs are read at accept and written back in S_EXEC, which a full response stalls.
// Reset (rst, synchronous): all levels empty, no task queued, running task 0,
// every task level reads 0 until spawned; the RAM contents themselves are not cleared.
module strict_priority_ready_queue
  import srq_pkg::*;
#(
  parameter int TASKS           = TASKS_DEF,
  parameter int PRIORITY_LEVELS = LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [ID_W-1:0]   task_id,
  input  logic [PRIO_W-1:0] task_priority,
  // response channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   chosen_task,
  output logic              found,
  output logic              spawn_error,
  output logic [ID_W-1:0]   running_task
);

  localparam int TW = $clog2(TASKS);
  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;

  state_t state;

  // captured request word
  action_t         act_q;
  logic [TW-1:0]   tidx_q;
  logic            id_ok_q;
  logic [LW-1:0]   prio_q;

  // per-level list pointers
  logic [TW-1:0]              level_head [PRIORITY_LEVELS];
  logic [TW-1:0]              level_tail [PRIORITY_LEVELS];
  logic [PRIORITY_LEVELS-1:0] level_nonempty;

  // per-task flags
  logic [TASKS-1:0] is_queued;
  logic [TASKS-1:0] lvl_written;
  logic [ID_W-1:0]  running;

  // RAM ports
  logic          lvl_we;
  logic [LW-1:0] lvl_rdata;
  logic          link_we;
  logic [TW-1:0] link_waddr;
  logic [TW-1:0] link_rdata;

  logic          in_acc;
  logic          exec_go;

  // lowest non-empty level
  logic          sch_found;
  logic [LW-1:0] sch_lvl;
  logic [TW-1:0] sch_head;

  // decode of the captured word
  logic          queued_t;
  logic [LW-1:0] wake_lvl;
  logic          do_append;
  logic [LW-1:0] app_lvl;
  logic          app_nonempty;
  logic          do_sched;
  logic          err_now;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign exec_go  = (state == S_EXEC) && (!out_valid || out_ready);

  // priority encoder over the level flags
  always_comb begin
    sch_found = 1'b0;
    sch_lvl   = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) begin
        sch_found = 1'b1;
        sch_lvl   = LW'(i);
      end
    end
  end
  assign sch_head = level_head[sch_lvl];

  // append / pop decisions for the word in flight
  always_comb begin
    queued_t     = is_queued[tidx_q];
    wake_lvl     = lvl_written[tidx_q] ? lvl_rdata : '0;
    do_append    = 1'b0;
    do_sched     = 1'b0;
    err_now      = 1'b0;
    app_lvl      = wake_lvl;
    unique case (act_q)
      ACT_SPAWN: begin
        app_lvl   = prio_q;
        err_now   = id_ok_q && queued_t;
        do_append = id_ok_q && !queued_t;
      end
      ACT_WAKE: begin
        do_append = id_ok_q && !queued_t;
      end
      ACT_SCHEDULE: begin
        do_sched = sch_found;
      end
      ACT_NOP: begin
        do_append = 1'b0;
      end
      default: begin
        do_append = 1'b0;
      end
    endcase
    app_nonempty = level_nonempty[app_lvl];
  end

  assign lvl_we     = exec_go && do_append && (act_q == ACT_SPAWN);
  assign link_we    = exec_go && do_append && app_nonempty;
  assign link_waddr = level_tail[app_lvl];

  // task level RAM: written on spawn, read at accept for wake
  srq_mem #(
    .DEPTH (TASKS),
    .WIDTH (LW)
  ) u_level_mem (
    .clk     (clk),
    .wr_en   (lvl_we),
    .wr_addr (tidx_q),
    .wr_data (prio_q),
    .rd_en   (in_acc),
    .rd_addr (TW'(task_id)),
    .rd_data (lvl_rdata)
  );

  // link RAM: next pointer per task, read at the head of the lowest busy level
  srq_mem #(
    .DEPTH (TASKS),
    .WIDTH (TW)
  ) u_link_mem (
    .clk     (clk),
    .wr_en   (link_we),
    .wr_addr (link_waddr),
    .wr_data (tidx_q),
    .rd_en   (in_acc),
    .rd_addr (sch_head),
    .rd_data (link_rdata)
  );

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // capture request word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_q   <= action_t'(action);
      tidx_q  <= TW'(task_id);
      id_ok_q <= (int'(task_id) < TASKS);
      prio_q  <= (int'(task_priority) >= PRIORITY_LEVELS) ?
                 LW'(PRIORITY_LEVELS - 1) : LW'(task_priority);
    end
  end

  // list and flag updates
  always_ff @(posedge clk) begin
    if (rst) begin
      level_nonempty <= '0;
      is_queued      <= '0;
      lvl_written    <= '0;
      running        <= '0;
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        level_head[i] <= '0;
        level_tail[i] <= '0;
      end
    end else if (exec_go) begin
      if (do_append) begin
        is_queued[tidx_q]   <= 1'b1;
        level_tail[app_lvl] <= tidx_q;
        if (!app_nonempty) begin
          level_head[app_lvl]     <= tidx_q;
          level_nonempty[app_lvl] <= 1'b1;
        end
        if (act_q == ACT_SPAWN) lvl_written[tidx_q] <= 1'b1;
      end
      if (do_sched) begin
        if (sch_head == level_tail[sch_lvl]) begin
          level_nonempty[sch_lvl] <= 1'b0;
        end else begin
          level_head[sch_lvl] <= link_rdata;
        end
        is_queued[sch_head] <= 1'b0;
        running             <= ID_W'(sch_head);
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      chosen_task  <= do_sched ? ID_W'(sch_head) : '0;
      found        <= do_sched;
      spawn_error  <= err_now;
      running_task <= do_sched ? ID_W'(sch_head) : running;
    end
  end

  // checks
  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_EXEC) && !in_ready)
    else $error("accepted word did not enter execute");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && out_valid && !out_ready |=> (state == S_EXEC))
    else $error("execute left while response slot full");

  a_found_running : assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> (running_task == chosen_task))
    else $error("scheduled task is not the running task");

  a_excl_flags : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && spawn_error))
    else $error("found and spawn error both set");

  a_empty_consistent : assert property (@(posedge clk) disable iff (rst)
    ($countones(is_queued) == 0) |-> (level_nonempty == '0))
    else $error("level marked busy with no queued task");

endmodule

FILE: hw/rtl/srq_mem.sv
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and held while rd_en is low.
// No dependencies.
module srq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
